### rtl/rvsi_pkg.sv
// Package for the robot velocity slew integrator.
// Holds widths, item kinds, sequencer states and the item and result structs.
// No dependencies.
`default_nettype none

package rvsi_pkg;

  localparam int COORD_BITS = 32;
  localparam int CMD_W      = 32;
  localparam int ANG_W      = 16;
  localparam int STEP_W     = 24;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int SUM_W      = 2 * MAG_W;
  localparam int REM_W      = MAG_W + 1;
  localparam int SHR_W      = MAG_W + 3;
  localparam int QUO_W      = STEP_W + 1;
  localparam int DVD_W      = MAG_W + STEP_W;
  localparam int MULA_W     = (MAG_W > CMD_W) ? MAG_W : CMD_W;
  localparam int PROD_W     = MULA_W + CMD_W;
  localparam int ALU_W      = SUM_W;
  localparam int CNT_MAX    = (MAG_W > QUO_W) ? MAG_W : QUO_W;
  localparam int CNT_W      = $clog2(CNT_MAX);

  localparam logic [CMD_W-1:0]  RECIP10    = 32'hCCCC_CCCD;
  localparam int                RECIP_SH   = 35;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd3277;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_MOVE   = 2'd1;
  localparam logic [1:0] KIND_SETPOS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SQ,
    ST_RINIT,
    ST_ROOT,
    ST_CHECK,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_APPLY,
    ST_MV_X,
    ST_MV_Y,
    ST_MV_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [CMD_W-1:0] cmd_vel_x;
    logic signed [CMD_W-1:0] cmd_vel_y;
    logic signed [ANG_W-1:0] cmd_ang_rate;
    logic signed [CMD_W-1:0] set_pos_x;
    logic signed [CMD_W-1:0] set_pos_y;
  } cmd_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] pos_x;
    logic signed [CMD_W-1:0] pos_y;
    logic signed [CMD_W-1:0] vel_x;
    logic signed [CMD_W-1:0] vel_y;
    logic signed [ANG_W-1:0] heading;
  } res_t;

endpackage

`default_nettype wire

### rtl/rvsi_alu.sv
// Shared add/subtract unit of the slew integrator.
// Serves the square accumulation, the square root and the division steps; uses rvsi_pkg.
`default_nettype none

module rvsi_alu (
  input  wire logic [rvsi_pkg::ALU_W-1:0] a,
  input  wire logic [rvsi_pkg::ALU_W-1:0] b,
  input  wire logic                       sub,
  output logic      [rvsi_pkg::ALU_W-1:0] res,
  output logic                            cout
);

  logic [rvsi_pkg::ALU_W-1:0] b_op;

  always_comb begin
    b_op        = sub ? ~b : b;
    {cout, res} = {1'b0, a} + {1'b0, b_op} + {{rvsi_pkg::ALU_W{1'b0}}, sub};
  end

endmodule

`default_nettype wire

### rtl/rvsi_core.sv
// Sequencer, motion state and working registers of the slew integrator.
// Drives rvsi_alu step by step and one shared multiplier; uses rvsi_pkg.
`default_nettype none

module rvsi_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [rvsi_pkg::STEP_W-1:0]  accel_step,
  input  wire logic                         start,
  output logic                              ready,
  input  wire rvsi_pkg::cmd_t               cmd,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output rvsi_pkg::res_t                    res
);

  localparam int CW = rvsi_pkg::COORD_BITS;
  localparam int MW = rvsi_pkg::MAG_W;
  localparam logic [rvsi_pkg::CNT_W-1:0] SQ_LAST  = rvsi_pkg::CNT_W'(rvsi_pkg::MAG_W - 1);
  localparam logic [rvsi_pkg::CNT_W-1:0] DIV_LAST = rvsi_pkg::CNT_W'(rvsi_pkg::QUO_W - 1);

  rvsi_pkg::state_t state, state_next;

  logic signed [CW-1:0]             pos [2];
  logic signed [CW-1:0]             vel [2];
  logic signed [CW-1:0]             tgt [2];
  logic [rvsi_pkg::ANG_W-1:0]       orient;
  logic [rvsi_pkg::ANG_W-1:0]       turn;
  logic [rvsi_pkg::CNT_W-1:0]       cnt;
  logic                             sel;

  logic signed [rvsi_pkg::CMD_W-1:0] cvx, cvy;
  logic [MW-1:0]                    mag [2];
  logic                             neg [2];
  logic [rvsi_pkg::SUM_W-1:0]       acc, mcand, rad;
  logic [MW-1:0]                    mplier;
  logic [rvsi_pkg::REM_W-1:0]       rem;
  logic [MW-1:0]                    root;
  logic [rvsi_pkg::PROD_W-1:0]      prod;
  logic [MW-1:0]                    drem;
  logic [rvsi_pkg::QUO_W-1:0]       qsh, quo;

  logic signed [MW-1:0]             dif   [2];
  logic [MW-1:0]                    mag_c [2];
  logic                             neg_c [2];
  logic [rvsi_pkg::SHR_W-1:0]       rem_sh;
  logic [MW+1:0]                    trial_r;
  logic [MW:0]                      trial_d;
  logic [rvsi_pkg::ALU_W-1:0]       alu_a, alu_b, alu_res;
  logic                             alu_sub, alu_ge;
  logic [rvsi_pkg::MULA_W-1:0]      mul_a;
  logic [rvsi_pkg::CMD_W-1:0]       mul_b;
  logic [rvsi_pkg::PROD_W-1:0]      mul_res;
  logic [rvsi_pkg::CMD_W-1:0]       mag_cx, mag_cy, q10;
  logic signed [rvsi_pkg::CMD_W-1:0] q10_pos, q10_neg;
  logic [CW-1:0]                    quo_ext;
  logic                             root_lt_step;

  rvsi_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .cout (alu_ge)
  );

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dif[i]   = MW'(tgt[i]) - MW'(vel[i]);
      neg_c[i] = dif[i][MW-1];
      mag_c[i] = neg_c[i] ? MW'(-dif[i]) : MW'(dif[i]);
    end
    rem_sh  = {rem[rvsi_pkg::REM_W-1:0], rad[rvsi_pkg::SUM_W-1 -: 2]};
    trial_r = {root, 2'b01};
    trial_d = {drem, qsh[rvsi_pkg::QUO_W-1]};
    mag_cx  = cvx[rvsi_pkg::CMD_W-1] ? rvsi_pkg::CMD_W'(-cvx) : rvsi_pkg::CMD_W'(cvx);
    mag_cy  = cvy[rvsi_pkg::CMD_W-1] ? rvsi_pkg::CMD_W'(-cvy) : rvsi_pkg::CMD_W'(cvy);
    q10     = rvsi_pkg::CMD_W'(prod >> rvsi_pkg::RECIP_SH);
    q10_pos = $signed(q10);
    q10_neg = -$signed(q10);
    quo_ext = CW'(quo);
    root_lt_step = {{rvsi_pkg::STEP_W{1'b0}}, root} < {{MW{1'b0}}, accel_step};
  end

  always_comb begin
    unique case (state)
      rvsi_pkg::ST_ROOT: begin
        alu_a   = rvsi_pkg::ALU_W'(rem_sh);
        alu_b   = rvsi_pkg::ALU_W'(trial_r);
        alu_sub = 1'b1;
      end
      rvsi_pkg::ST_DIV: begin
        alu_a   = rvsi_pkg::ALU_W'(trial_d);
        alu_b   = rvsi_pkg::ALU_W'(root);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc;
        alu_b   = mcand;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      rvsi_pkg::ST_MV_X: begin
        mul_a = rvsi_pkg::MULA_W'(mag_cy);
        mul_b = rvsi_pkg::RECIP10;
      end
      rvsi_pkg::ST_MV_Y: begin
        mul_a = rvsi_pkg::MULA_W'(mag_cx);
        mul_b = rvsi_pkg::RECIP10;
      end
      default: begin
        mul_a = rvsi_pkg::MULA_W'(mag[sel]);
        mul_b = rvsi_pkg::CMD_W'(accel_step);
      end
    endcase
    mul_res = {{(rvsi_pkg::PROD_W - rvsi_pkg::MULA_W){1'b0}}, mul_a}
            * {{(rvsi_pkg::PROD_W - rvsi_pkg::CMD_W){1'b0}}, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      rvsi_pkg::ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          case (cmd.kind)
            rvsi_pkg::KIND_TICK: state_next = rvsi_pkg::ST_TICK;
            rvsi_pkg::KIND_MOVE: state_next = rvsi_pkg::ST_MV_X;
            default:             state_next = rvsi_pkg::ST_DONE;
          endcase
        end
      end
      rvsi_pkg::ST_TICK:  state_next = rvsi_pkg::ST_SQ;
      rvsi_pkg::ST_SQ: begin
        if (cnt == SQ_LAST && sel) state_next = rvsi_pkg::ST_RINIT;
      end
      rvsi_pkg::ST_RINIT: state_next = rvsi_pkg::ST_ROOT;
      rvsi_pkg::ST_ROOT: begin
        if (cnt == SQ_LAST) state_next = rvsi_pkg::ST_CHECK;
      end
      rvsi_pkg::ST_CHECK: begin
        if (root_lt_step || root == '0) state_next = rvsi_pkg::ST_DONE;
        else                             state_next = rvsi_pkg::ST_MUL;
      end
      rvsi_pkg::ST_MUL:   state_next = rvsi_pkg::ST_DINIT;
      rvsi_pkg::ST_DINIT: state_next = rvsi_pkg::ST_DIV;
      rvsi_pkg::ST_DIV: begin
        if (cnt == DIV_LAST) state_next = rvsi_pkg::ST_APPLY;
      end
      rvsi_pkg::ST_APPLY: state_next = sel ? rvsi_pkg::ST_DONE : rvsi_pkg::ST_MUL;
      rvsi_pkg::ST_MV_X:  state_next = rvsi_pkg::ST_MV_Y;
      rvsi_pkg::ST_MV_Y:  state_next = rvsi_pkg::ST_MV_END;
      rvsi_pkg::ST_MV_END: state_next = rvsi_pkg::ST_DONE;
      rvsi_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = rvsi_pkg::ST_IDLE;
      end
      default: state_next = rvsi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        tgt[i] <= '0;
      end
      orient <= '0;
      turn   <= '0;
      cnt    <= '0;
      sel    <= 1'b0;
    end else begin
      case (state)
        rvsi_pkg::ST_IDLE: begin
          if (start) begin
            case (cmd.kind)
              rvsi_pkg::KIND_MOVE: turn <= cmd.cmd_ang_rate;
              rvsi_pkg::KIND_SETPOS: begin
                pos[0] <= CW'(cmd.set_pos_x);
                pos[1] <= CW'(cmd.set_pos_y);
                vel[0] <= '0;
                vel[1] <= '0;
                turn   <= '0;
              end
              default: ;
            endcase
          end
        end
        rvsi_pkg::ST_TICK: begin
          pos[0] <= pos[0] + vel[0];
          pos[1] <= pos[1] + vel[1];
          orient <= orient + turn;
          cnt    <= '0;
          sel    <= 1'b0;
        end
        rvsi_pkg::ST_SQ: begin
          if (cnt == SQ_LAST) begin
            cnt <= '0;
            sel <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        rvsi_pkg::ST_RINIT: cnt <= '0;
        rvsi_pkg::ST_ROOT:  cnt <= cnt + 1'b1;
        rvsi_pkg::ST_CHECK: begin
          sel <= 1'b0;
          if (root_lt_step) begin
            vel[0] <= tgt[0];
            vel[1] <= tgt[1];
          end
        end
        rvsi_pkg::ST_DINIT: cnt <= '0;
        rvsi_pkg::ST_DIV:   cnt <= cnt + 1'b1;
        rvsi_pkg::ST_APPLY: begin
          if (neg[sel]) vel[sel] <= vel[sel] - $signed(quo_ext);
          else          vel[sel] <= vel[sel] + $signed(quo_ext);
          sel <= 1'b1;
        end
        rvsi_pkg::ST_MV_Y: begin
          tgt[0] <= cvy[rvsi_pkg::CMD_W-1] ? CW'(q10_pos) : CW'(q10_neg);
        end
        rvsi_pkg::ST_MV_END: begin
          tgt[1] <= cvx[rvsi_pkg::CMD_W-1] ? CW'(q10_neg) : CW'(q10_pos);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rvsi_pkg::ST_IDLE: begin
        if (start) begin
          cvx <= cmd.cmd_vel_x;
          cvy <= cmd.cmd_vel_y;
        end
      end
      rvsi_pkg::ST_TICK: begin
        mag[0] <= mag_c[0];
        mag[1] <= mag_c[1];
        neg[0] <= neg_c[0];
        neg[1] <= neg_c[1];
        acc    <= '0;
        mcand  <= rvsi_pkg::SUM_W'(mag_c[0]);
        mplier <= mag_c[0];
      end
      rvsi_pkg::ST_SQ: begin
        if (mplier[0]) acc <= alu_res;
        if (cnt == SQ_LAST && !sel) begin
          mcand  <= rvsi_pkg::SUM_W'(mag[1]);
          mplier <= mag[1];
        end else begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
      rvsi_pkg::ST_RINIT: begin
        rad  <= acc;
        rem  <= '0;
        root <= '0;
      end
      rvsi_pkg::ST_ROOT: begin
        rad <= rad << 2;
        if (alu_ge) begin
          rem  <= alu_res[rvsi_pkg::REM_W-1:0];
          root <= {root[MW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[rvsi_pkg::REM_W-1:0];
          root <= {root[MW-2:0], 1'b0};
        end
      end
      rvsi_pkg::ST_MUL, rvsi_pkg::ST_MV_X, rvsi_pkg::ST_MV_Y: prod <= mul_res;
      rvsi_pkg::ST_DINIT: begin
        drem <= MW'(prod[rvsi_pkg::DVD_W-1:rvsi_pkg::QUO_W]);
        qsh  <= prod[rvsi_pkg::QUO_W-1:0];
        quo  <= '0;
      end
      rvsi_pkg::ST_DIV: begin
        qsh <= qsh << 1;
        quo <= {quo[rvsi_pkg::QUO_W-2:0], alu_ge};
        if (alu_ge) drem <= alu_res[MW-1:0];
        else        drem <= trial_d[MW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    res.pos_x   = rvsi_pkg::CMD_W'(pos[0]);
    res.pos_y   = rvsi_pkg::CMD_W'(pos[1]);
    res.vel_x   = rvsi_pkg::CMD_W'(vel[0]);
    res.vel_y   = rvsi_pkg::CMD_W'(vel[1]);
    res.heading = orient;
  end

endmodule

`default_nettype wire

### rtl/robot_velocity_slew_integrator.sv
// Robot velocity slew integrator: 2D position and velocity in Q16.16, 16-bit heading.
// Input item channel in_valid/in_ready, result channel out_valid/out_ready,
// one accel_step register written through cfg_we/cfg_wdata.
// Each accepted item (tick, move command, set position) yields one result item
// carrying the state after the item. An unused kind returns the state unchanged.
// A move command takes one reciprocal multiply per component; a tick either snaps
// the velocity to its target or slews it toward the target.
// A tick uses the shared add/subtract unit: two 33-step shift-add squarings,
// 33 square root steps and, when it slews, two 25-step divisions, each preceded
// by a multiply and a load step.
// One item is worked on at a time; in_ready is high only while the core is idle.
// A finished result sits in an output register, so the next item may be taken
// while the receiver stalls; the core then holds its result until the register
// frees. Reset clears all motion state, sets accel_step to 3277 and drops any
// pending result.
`default_nettype none

module robot_velocity_slew_integrator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rvsi_pkg::STEP_W-1:0]        cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         kind,
  input  wire logic signed [rvsi_pkg::CMD_W-1:0]  cmd_vel_x,
  input  wire logic signed [rvsi_pkg::CMD_W-1:0]  cmd_vel_y,
  input  wire logic signed [rvsi_pkg::ANG_W-1:0]  cmd_ang_rate,
  input  wire logic signed [rvsi_pkg::CMD_W-1:0]  set_pos_x,
  input  wire logic signed [rvsi_pkg::CMD_W-1:0]  set_pos_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [rvsi_pkg::CMD_W-1:0]       pos_x,
  output logic signed [rvsi_pkg::CMD_W-1:0]       pos_y,
  output logic signed [rvsi_pkg::CMD_W-1:0]       vel_x,
  output logic signed [rvsi_pkg::CMD_W-1:0]       vel_y,
  output logic signed [rvsi_pkg::ANG_W-1:0]       heading
);

  logic [rvsi_pkg::STEP_W-1:0] accel_step;
  rvsi_pkg::cmd_t              cmd;
  rvsi_pkg::res_t              res;
  rvsi_pkg::res_t              out_r;
  logic                        res_valid;
  logic                        res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step <= rvsi_pkg::STEP_RESET;
    end else if (cfg_we) begin
      accel_step <= cfg_wdata;
    end
  end

  always_comb begin
    cmd.kind         = kind;
    cmd.cmd_vel_x    = cmd_vel_x;
    cmd.cmd_vel_y    = cmd_vel_y;
    cmd.cmd_ang_rate = cmd_ang_rate;
    cmd.set_pos_x    = set_pos_x;
    cmd.set_pos_y    = set_pos_y;
  end

  rvsi_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accel_step (accel_step),
    .start      (in_valid),
    .ready      (in_ready),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign pos_x   = out_r.pos_x;
  assign pos_y   = out_r.pos_y;
  assign vel_x   = out_r.vel_x;
  assign vel_y   = out_r.vel_y;
  assign heading = out_r.heading;

endmodule

`default_nettype wire
